// ===== hdl/rgb_color_effect_filter_unit_macros.svh =====
// ----------------------------------------------------------------------------
// RGB colour effect filter: assertion macros
// Shared property wrappers, sampled on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef RGB_COLOR_EFFECT_FILTER_UNIT_MACROS_SVH
`define RGB_COLOR_EFFECT_FILTER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define RGBCEF_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RGBCEF_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define RGBCEF_ASSERT_SAME(name, ante, cons, msg)
`define RGBCEF_ASSERT_NEXT(name, ante, cons, msg)

`endif

`endif

// ===== hdl/rgbcef_pkg.sv =====
// ----------------------------------------------------------------------------
// RGB colour effect filter package
// Effect codes, channel widths and the fixed-point sepia and grey constants.
// ----------------------------------------------------------------------------
package rgbcef_pkg;

    localparam int CHANNEL_W = 8;
    localparam int PIXEL_W   = 3 * CHANNEL_W;

    // Effect selected by the configuration register.
    typedef enum logic [1:0] {
        EFFECT_GRAYSCALE = 2'd0,
        EFFECT_NEGATIVE  = 2'd1,
        EFFECT_SEPIA     = 2'd2,
        EFFECT_PASTEL    = 2'd3
    } effect_mode_t;

    // Control that travels alongside a pixel through the pipeline.
    typedef struct packed {
        logic         valid;
        effect_mode_t mode;
    } pix_ctrl_t;

    localparam logic [CHANNEL_W-1:0] CHANNEL_MAX   = 8'd255;
    localparam logic [CHANNEL_W-1:0] PASTEL_OFFSET = 8'd127;
    localparam logic [PIXEL_W-1:0]   WHITE_PIXEL   = 24'hFFFFFF;

    // Sepia matrix in thousandths; rows give output red, green, blue.
    localparam int COEF_W = 10;
    localparam logic [COEF_W-1:0] SEPIA_COEF [3][3] = '{
        '{10'd393, 10'd769, 10'd189},
        '{10'd349, 10'd686, 10'd168},
        '{10'd272, 10'd534, 10'd131}
    };

    // Weighted sums reach 344505 and so fit in 19 bits.
    localparam int SEPIA_SUM_W = 19;

    // Division by 1000 as a multiply by ceil(2^28 / 1000) and a shift. The
    // overshoot stays below 1/1000 for every sum up to 344505, the largest
    // weighted sum, so the quotient is exact.
    localparam int                      SEPIA_SHIFT  = 28;
    localparam logic [SEPIA_SUM_W-1:0]  SEPIA_RECIP  = 19'd268436;
    localparam int                      SEPIA_PROD_W = 2 * SEPIA_SUM_W;
    localparam int                      SEPIA_QUOT_W = SEPIA_PROD_W - SEPIA_SHIFT;

    // Grey sum of three channels reaches 765; division by 3 as a multiply by
    // ceil(2^11 / 3) and a shift, exact over that range.
    localparam int                      GREY_SUM_W   = 10;
    localparam int                      GREY_SHIFT   = 11;
    localparam int                      GREY_PROD_W  = GREY_SHIFT + CHANNEL_W;
    localparam logic [GREY_PROD_W-1:0]  GREY_RECIP   = 19'd683;

endpackage

// ===== hdl/rgbcef_core.sv =====
// ----------------------------------------------------------------------------
// RGB colour effect filter datapath
// Two register stages: channel sums and simple effects, then the constant
// divisions, sepia clamp and effect selection into the result register.
// ----------------------------------------------------------------------------
`include "rgb_color_effect_filter_unit_macros.svh"

module rgbcef_core
    import rgbcef_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  pix_ctrl_t            in_ctrl,
    input  logic [PIXEL_W-1:0]   in_pixel,
    output logic                 done,
    output logic [PIXEL_W-1:0]   result_color
);

    logic [CHANNEL_W-1:0] chan [3];

    logic [SEPIA_SUM_W-1:0] sepia_sum_next [3];
    logic [GREY_SUM_W-1:0]  grey_sum_next;
    logic [PIXEL_W-1:0]     pastel_next;

    pix_ctrl_t              b_ctrl_reg;
    logic [SEPIA_SUM_W-1:0] b_sepia_sum_reg [3];
    logic [GREY_SUM_W-1:0]  b_grey_sum_reg;
    logic [PIXEL_W-1:0]     b_neg_reg;
    logic [PIXEL_W-1:0]     b_pastel_reg;
    logic                   b_white_reg;

    logic [SEPIA_PROD_W-1:0] sepia_prod [3];
    logic [SEPIA_QUOT_W-1:0] sepia_quot [3];
    logic [CHANNEL_W-1:0]    sepia_chan [3];
    logic [GREY_PROD_W-1:0]  grey_prod;
    logic [CHANNEL_W-1:0]    grey;

    pix_ctrl_t              c_ctrl_reg;
    logic [PIXEL_W-1:0]     result_next;
    logic [PIXEL_W-1:0]     result_reg;

    // Split the pixel into red, green and blue.
    assign chan[0] = in_pixel[3*CHANNEL_W-1:2*CHANNEL_W];
    assign chan[1] = in_pixel[2*CHANNEL_W-1:CHANNEL_W];
    assign chan[2] = in_pixel[CHANNEL_W-1:0];

    // First stage: weighted sepia sums, grey sum and pastel channels.
    always_comb
    begin
        for (int row = 0; row < 3; row++)
        begin
            sepia_sum_next[row] =
                SEPIA_SUM_W'(SEPIA_COEF[row][0]) * SEPIA_SUM_W'(chan[0])
              + SEPIA_SUM_W'(SEPIA_COEF[row][1]) * SEPIA_SUM_W'(chan[1])
              + SEPIA_SUM_W'(SEPIA_COEF[row][2]) * SEPIA_SUM_W'(chan[2]);
        end
        grey_sum_next = GREY_SUM_W'(chan[0]) + GREY_SUM_W'(chan[1])
                      + GREY_SUM_W'(chan[2]);
        for (int c = 0; c < 3; c++)
        begin
            pastel_next[PIXEL_W-1-c*CHANNEL_W -: CHANNEL_W] =
                (chan[c] >> 1) + PASTEL_OFFSET;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_ctrl_reg <= '0;
            c_ctrl_reg <= '0;
        end
        else
        begin
            b_ctrl_reg <= in_ctrl;
            c_ctrl_reg <= b_ctrl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        b_sepia_sum_reg <= sepia_sum_next;
        b_grey_sum_reg  <= grey_sum_next;
        b_neg_reg       <= ~in_pixel;
        b_pastel_reg    <= pastel_next;
        b_white_reg     <= (in_pixel == WHITE_PIXEL);
    end

    // Second stage: divide by the reciprocal multiplies and clamp sepia.
    always_comb
    begin
        for (int row = 0; row < 3; row++)
        begin
            sepia_prod[row] = SEPIA_PROD_W'(b_sepia_sum_reg[row])
                            * SEPIA_PROD_W'(SEPIA_RECIP);
            sepia_quot[row] = sepia_prod[row][SEPIA_PROD_W-1:SEPIA_SHIFT];
            if (sepia_quot[row] > SEPIA_QUOT_W'(CHANNEL_MAX))
            begin
                sepia_chan[row] = CHANNEL_MAX;
            end
            else
            begin
                sepia_chan[row] = sepia_quot[row][CHANNEL_W-1:0];
            end
        end
        grey_prod = GREY_PROD_W'(b_grey_sum_reg) * GREY_RECIP;
        grey      = grey_prod[GREY_PROD_W-1:GREY_SHIFT];
    end

    // Pick the configured effect.
    always_comb
    begin
        case (b_ctrl_reg.mode)
            EFFECT_GRAYSCALE:
            begin
                if (b_white_reg)
                begin
                    result_next = WHITE_PIXEL;
                end
                else
                begin
                    result_next = {grey, grey, grey};
                end
            end
            EFFECT_NEGATIVE: result_next = b_neg_reg;
            EFFECT_SEPIA:    result_next = {sepia_chan[0], sepia_chan[1], sepia_chan[2]};
            EFFECT_PASTEL:   result_next = b_pastel_reg;
            default:         result_next = b_pastel_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done         = c_ctrl_reg.valid;
    assign result_color = result_reg;

    // Every transfer in leaves as done through the b and c control registers.
    `RGBCEF_ASSERT_SAME(a_latency, in_ctrl.valid, ##2 done, "pixel did not emerge after two cycles")
    // Grey output has three equal channels.
    `RGBCEF_ASSERT_SAME(a_grey_equal,
        done && (c_ctrl_reg.mode == EFFECT_GRAYSCALE),
        (result_color[23:16] == result_color[15:8]) && (result_color[15:8] == result_color[7:0]),
        "grey result has unequal channels")
    // Negative output is the complement of the pixel that went in.
    `RGBCEF_ASSERT_SAME(a_negative,
        done && (c_ctrl_reg.mode == EFFECT_NEGATIVE),
        result_color == ~$past(in_pixel, 2),
        "negative result does not match its input")
    // Pastel channels never fall below the offset.
    `RGBCEF_ASSERT_SAME(a_pastel_floor,
        done && (c_ctrl_reg.mode == EFFECT_PASTEL),
        (result_color[23:16] >= PASTEL_OFFSET) && (result_color[15:8] >= PASTEL_OFFSET)
            && (result_color[7:0] >= PASTEL_OFFSET),
        "pastel channel below offset")

endmodule

// ===== hdl/rgb_color_effect_filter_unit.sv =====
// ----------------------------------------------------------------------------
// RGB colour effect filter unit
// Recolours one 0xRRGGBB pixel per transfer by grayscale, negative, sepia or
// pastel, as chosen by the effect mode register.
// ----------------------------------------------------------------------------
//  Channel   Ports                           Transfer
//  config    cfg_we, cfg_wdata               cfg_we high at a clock edge
//  pixel in  start, busy, pixel_color        start high and busy low
//  result    done, result_color              done high for one cycle
//
//  A pixel may be started in every cycle; busy is never raised.
//  Each result passes from its start through the input register, the sum
//  register, then the result register after the divide-by-constant multiplies.
//  Reset clears the pipeline valid bits and sets the mode to grayscale.
//  The receiver cannot stall, so results are never held back.
// ----------------------------------------------------------------------------
module rgb_color_effect_filter_unit
    import rgbcef_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_wdata,
    input  logic                 start,
    output logic                 busy,
    input  logic [PIXEL_W-1:0]   pixel_color,
    output logic                 done,
    output logic [PIXEL_W-1:0]   result_color
);

    effect_mode_t         mode_reg;
    pix_ctrl_t            a_ctrl_reg;
    pix_ctrl_t            a_ctrl_next;
    logic [PIXEL_W-1:0]   a_pixel_reg;

    // The pipeline takes a pixel every cycle.
    assign busy = 1'b0;

    always_comb
    begin
        a_ctrl_next.valid = start && !busy;
        a_ctrl_next.mode  = mode_reg;
    end

    // Effect mode register and input stage valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= EFFECT_GRAYSCALE;
            a_ctrl_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                mode_reg <= effect_mode_t'(cfg_wdata);
            end
            a_ctrl_reg <= a_ctrl_next;
        end
    end

    // Input pixel register.
    always_ff @(posedge clk)
    begin
        if (a_ctrl_next.valid)
        begin
            a_pixel_reg <= pixel_color;
        end
    end

    rgbcef_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_ctrl      (a_ctrl_reg),
        .in_pixel     (a_pixel_reg),
        .done         (done),
        .result_color (result_color)
    );

endmodule
